// ===== hdl/voice_slot_allocator_top_macros.svh =====
// Assertion macros shared by the voice slot allocator RTL.
`ifndef VOICE_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define VOICE_SLOT_ALLOCATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define VSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voice slot allocator check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define VSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voice slot allocator check failed");

`else

`define VSA_ASSERT_IMP(label, ante, cons)
`define VSA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/vsa_pkg.sv =====
// Types and constants of the voice slot allocator.
package vsa_pkg;

  localparam int PITCH_W = 19;
  localparam int TOL_W   = 8;
  localparam int CMD_W   = 2;
  localparam int ACT_W   = 2;
  localparam int FSLOT_W = 3;
  localparam int OSLOT_W = 3;
  localparam int MASK_W  = 8;

  localparam logic [TOL_W-1:0] TOL_RESET = 8'd8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_NOTE_ON    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_VOICE_DONE = 2'd2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } vsa_state_t;

  // Per-slot verdict of the shared compare unit
  typedef struct packed {
    logic near;
    logic older;
  } vsa_cmp_t;

endpackage

// ===== hdl/voice_slot_allocator_top.sv =====
// Voice slot allocator: top level with slot state, scan sequencer and result register.
//
// Usage: items enter on in_valid/in_ready with command, pitch and finished_slot.
// A note on or note off item walks the VOICES slots one per cycle through a
// single compare unit (pitch window test and generation age test), then goes
// to the done state, which decides the result and updates slot state; voice
// finished and unused commands skip the scan. The result item is presented on
// out_valid/out_ready with action, chosen_slot, slot_pitch, release_mask,
// was_retrigger and was_stolen, and is held until taken. in_ready is high only
// between items. A waiting result does not block the next item: it is accepted
// and scanned, and only its final decide step holds until the output register
// is free. The match_tolerance register must be written through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block itself does not
// enforce this. Synchronous reset clears all slots to idle, the generation
// counter to zero, the tolerance to 8, and drops any pending result.
module voice_slot_allocator_top #(
  parameter int VOICES   = 8,
  parameter int GEN_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [vsa_pkg::TOL_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [vsa_pkg::CMD_W-1:0]    command,
  input  logic [vsa_pkg::PITCH_W-1:0]  pitch,
  input  logic [vsa_pkg::FSLOT_W-1:0]  finished_slot,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vsa_pkg::ACT_W-1:0]    action,
  output logic [vsa_pkg::OSLOT_W-1:0]  chosen_slot,
  output logic [vsa_pkg::PITCH_W-1:0]  slot_pitch,
  output logic [vsa_pkg::MASK_W-1:0]   release_mask,
  output logic                         was_retrigger,
  output logic                         was_stolen
);

`include "voice_slot_allocator_top_macros.svh"

  localparam int SLOT_W = $clog2(VOICES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VOICES - 1);

  vsa_pkg::vsa_state_t state, state_next;

  logic [vsa_pkg::TOL_W-1:0]   match_tolerance;
  logic [vsa_pkg::CMD_W-1:0]   cmd_q;
  logic [vsa_pkg::PITCH_W-1:0] pitch_q;
  logic [vsa_pkg::FSLOT_W-1:0] fs_q;

  // Scan registers
  logic [SLOT_W-1:0]   idx;
  logic                match_found;
  logic [SLOT_W-1:0]   match_idx;
  logic                idle_found;
  logic [SLOT_W-1:0]   idle_idx;
  logic [SLOT_W-1:0]   min_idx;
  logic [GEN_BITS-1:0] min_gen;
  logic [VOICES-1:0]   off_mask;

  // Slot state
  logic [VOICES-1:0]           slot_active;
  logic [vsa_pkg::PITCH_W-1:0] slot_freq [VOICES];
  logic [GEN_BITS-1:0]         slot_gen  [VOICES];
  logic [GEN_BITS-1:0]         gen_ctr;
  logic [GEN_BITS-1:0]         gen_ctr_next;

  vsa_pkg::vsa_cmp_t cmp;

  logic                     accept;
  logic                     load;
  logic [SLOT_W-1:0]        pick;
  logic [VOICES-1:0]        rel_mask;
  logic [SLOT_W+2:0]        pick_ext;
  logic [VOICES+7:0]        mask_ext;
  logic [vsa_pkg::ACT_W-1:0]   action_next;
  logic [vsa_pkg::OSLOT_W-1:0] chosen_next;
  logic [vsa_pkg::PITCH_W-1:0] pitch_next;
  logic [vsa_pkg::MASK_W-1:0]  mask_next;
  logic                        retrig_next;
  logic                        stolen_next;

  // Compare the slot under the scan index
  vsa_slot_cmp #(
    .GEN_BITS (GEN_BITS)
  ) u_cmp (
    .slot_pitch (slot_freq[idx]),
    .pitch      (pitch_q),
    .tolerance  (match_tolerance),
    .slot_gen   (slot_gen[idx]),
    .min_gen    (min_gen),
    .first      (idx == '0),
    .result     (cmp)
  );

  assign accept       = in_valid && in_ready;
  assign load         = (state == vsa_pkg::ST_DONE) && (!out_valid || out_ready);
  assign gen_ctr_next = gen_ctr + GEN_BITS'(1);

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      vsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == vsa_pkg::CMD_NOTE_ON || command == vsa_pkg::CMD_NOTE_OFF) begin
            state_next = vsa_pkg::ST_SCAN;
          end else begin
            state_next = vsa_pkg::ST_DONE;
          end
        end
      end
      vsa_pkg::ST_SCAN: begin
        if (idx == LAST_SLOT) begin
          state_next = vsa_pkg::ST_DONE;
        end
      end
      vsa_pkg::ST_DONE: begin
        if (load) begin
          state_next = vsa_pkg::ST_IDLE;
        end
      end
      default: state_next = vsa_pkg::ST_IDLE;
    endcase
  end

  // Pick the slot (retrigger, then idle, then oldest) and form the release mask
  always_comb begin
    pick = min_idx;
    if (idle_found) begin
      pick = idle_idx;
    end
    if (match_found) begin
      pick = match_idx;
    end
    if (pitch_q == '0) begin
      rel_mask = off_mask;
    end else if (match_found) begin
      rel_mask = VOICES'(1) << match_idx;
    end else begin
      rel_mask = '0;
    end
    pick_ext = (SLOT_W + 3)'(pick);
    mask_ext = (VOICES + 8)'(rel_mask);
  end

  // Form the result item
  always_comb begin
    action_next = vsa_pkg::ACT_NONE;
    chosen_next = '0;
    pitch_next  = '0;
    mask_next   = '0;
    retrig_next = 1'b0;
    stolen_next = 1'b0;
    case (cmd_q)
      vsa_pkg::CMD_NOTE_ON: begin
        action_next = vsa_pkg::ACT_START;
        chosen_next = pick_ext[vsa_pkg::OSLOT_W-1:0];
        pitch_next  = pitch_q;
        retrig_next = match_found;
        stolen_next = !match_found && !idle_found;
      end
      vsa_pkg::CMD_NOTE_OFF: begin
        if (rel_mask != '0) begin
          action_next = vsa_pkg::ACT_RELEASE;
          mask_next   = mask_ext[vsa_pkg::MASK_W-1:0];
        end
      end
      default: begin
        action_next = vsa_pkg::ACT_NONE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control: tolerance, scan flags, slot activity, generation, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= vsa_pkg::TOL_RESET;
      idx             <= '0;
      match_found     <= 1'b0;
      idle_found      <= 1'b0;
      slot_active     <= '0;
      gen_ctr         <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        match_tolerance <= cfg_wr_data;
      end
      if (accept) begin
        idx         <= '0;
        match_found <= 1'b0;
        idle_found  <= 1'b0;
      end else if (state == vsa_pkg::ST_SCAN) begin
        idx <= idx + SLOT_W'(1);
        if (!match_found && slot_active[idx] && cmp.near) begin
          match_found <= 1'b1;
        end
        if (!idle_found && !slot_active[idx]) begin
          idle_found <= 1'b1;
        end
      end
      if (load) begin
        if (cmd_q == vsa_pkg::CMD_NOTE_ON) begin
          gen_ctr           <= gen_ctr_next;
          slot_active[pick] <= 1'b1;
        end else if (cmd_q == vsa_pkg::CMD_VOICE_DONE) begin
          for (int i = 0; i < VOICES; i++) begin
            if (int'(fs_q) == i) begin
              slot_active[i] <= 1'b0;
            end
          end
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: captured item, scan results, slot pitch and generation, result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= command;
      pitch_q  <= pitch;
      fs_q     <= finished_slot;
      off_mask <= '0;
    end else if (state == vsa_pkg::ST_SCAN) begin
      if (!match_found && slot_active[idx] && cmp.near) begin
        match_idx <= idx;
      end
      if (!idle_found && !slot_active[idx]) begin
        idle_idx <= idx;
      end
      if (cmp.older) begin
        min_idx <= idx;
        min_gen <= slot_gen[idx];
      end
      off_mask[idx] <= slot_active[idx];
    end
    if (load) begin
      if (cmd_q == vsa_pkg::CMD_NOTE_ON) begin
        slot_freq[pick] <= pitch_q;
        slot_gen[pick]  <= gen_ctr_next;
      end
      action        <= action_next;
      chosen_slot   <= chosen_next;
      slot_pitch    <= pitch_next;
      release_mask  <= mask_next;
      was_retrigger <= retrig_next;
      was_stolen    <= stolen_next;
    end
  end

  // Checks
  `VSA_ASSERT_IMP(a_start_no_mask, out_valid && action == vsa_pkg::ACT_START, release_mask == '0)
  `VSA_ASSERT_IMP(a_retrig_not_stolen, out_valid, !(was_retrigger && was_stolen))
  `VSA_ASSERT_NEXT(a_note_on_scans, accept && command == vsa_pkg::CMD_NOTE_ON,
                   state == vsa_pkg::ST_SCAN)
  `VSA_ASSERT_NEXT(a_note_on_keeps_active, load && cmd_q == vsa_pkg::CMD_NOTE_ON,
                   $countones(slot_active) >= $past($countones(slot_active)))

endmodule

// ===== hdl/vsa_slot_cmp.sv =====
// Shared compare unit: pitch distance test and generation age test for one slot.
module vsa_slot_cmp #(
  parameter int GEN_BITS = 32
) (
  input  logic [vsa_pkg::PITCH_W-1:0] slot_pitch,
  input  logic [vsa_pkg::PITCH_W-1:0] pitch,
  input  logic [vsa_pkg::TOL_W-1:0]   tolerance,
  input  logic [GEN_BITS-1:0]         slot_gen,
  input  logic [GEN_BITS-1:0]         min_gen,
  input  logic                        first,
  output vsa_pkg::vsa_cmp_t           result
);

  logic [vsa_pkg::PITCH_W-1:0] diff;

  // Take the absolute pitch distance
  always_comb begin
    if (slot_pitch > pitch) begin
      diff = slot_pitch - pitch;
    end else begin
      diff = pitch - slot_pitch;
    end
  end

  // Strict window test; first slot always seeds the oldest search
  always_comb begin
    result.near  = diff < vsa_pkg::PITCH_W'(tolerance);
    result.older = first || (slot_gen < min_gen);
  end

endmodule
